// File: hw/rtl/cfp_pkg.sv
// Shared types and constants for the checksummed frame parser.
// Used by cfp_hdr_match, cfp_frame_fsm and checksummed_frame_parser.
package cfp_pkg;

	localparam int unsigned NUM_TYPES = 7;
	localparam int unsigned TYPE_W    = 3;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_SIZE = 2'd1,
		PH_BODY = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		KIND_START   = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_END     = 2'd2
	} kind_t;

	typedef struct packed {
		logic       emit;
		logic [1:0] item_kind;
		logic [7:0] data_byte;
		logic [7:0] forward_length;
		logic       frame_good;
		logic       is_last;
	} result_t;

	typedef struct packed {
		logic              hit;
		logic [TYPE_W-1:0] frame_type;
	} match_t;

	// Frame type k carries tag 0xFF minus k.
	function automatic logic [7:0] tag_of(input logic [TYPE_W-1:0] t);
		tag_of = 8'hFF - {5'b0, t};
	endfunction

	// Reset value of header register k.
	function automatic logic [7:0] hdr_reset(input logic [TYPE_W-1:0] k);
		hdr_reset = 8'hFF - {5'b0, k};
	endfunction

endpackage

// File: hw/rtl/cfp_hdr_match.sv
// Header registers and priority header match.
// Depends on cfp_pkg.
module cfp_hdr_match (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [2:0]                cfg_addr,
	input  logic [7:0]                cfg_data,
	input  logic [7:0]                rx_byte,
	output cfp_pkg::match_t           match
);
	import cfp_pkg::*;

	logic [7:0] hdr_q [NUM_TYPES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_TYPES; k++) begin
				hdr_q[k] <= hdr_reset(TYPE_W'(k));
			end
		end else if (cfg_we && (cfg_addr < 3'(NUM_TYPES))) begin
			hdr_q[cfg_addr] <= cfg_data;
		end
	end

	// Scan from the highest index down so the lowest-numbered match wins.
	always_comb begin
		match.hit        = 1'b0;
		match.frame_type = '0;
		for (int k = NUM_TYPES - 1; k >= 0; k--) begin
			if (rx_byte == hdr_q[k]) begin
				match.hit        = 1'b1;
				match.frame_type = TYPE_W'(k);
			end
		end
	end

endmodule

// File: hw/rtl/cfp_frame_fsm.sv
// Frame state machine with running Fletcher-8 sums and result formation.
// Depends on cfp_pkg; takes the header match from cfp_hdr_match.
module cfp_frame_fsm (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step_en,
	input  logic [7:0]           rx_byte,
	input  cfp_pkg::match_t      match,
	output cfp_pkg::result_t     res
);
	import cfp_pkg::*;

	phase_t              phase_q, phase_d;
	logic [TYPE_W-1:0]   type_q, type_d;
	logic [7:0]          size_q, size_d;
	logic [7:0]          pos_q, pos_d;
	logic [7:0]          sum1_q, sum1_d;
	logic [7:0]          sum2_q, sum2_d;
	logic                matched_q, matched_d;
	logic [8:0]          pos3;
	logic [8:0]          pos2;
	logic [8:0]          size9;
	logic [7:0]          sum1_new;

	assign pos3     = {1'b0, pos_q} + 9'd3;
	assign pos2     = {1'b0, pos_q} + 9'd2;
	assign size9    = {1'b0, size_q};
	assign sum1_new = sum1_q + rx_byte;

	// Next state.
	always_comb begin
		phase_d   = phase_q;
		type_d    = type_q;
		size_d    = size_q;
		pos_d     = pos_q;
		sum1_d    = sum1_q;
		sum2_d    = sum2_q;
		matched_d = matched_q;
		case (phase_q)
			PH_SIZE: begin
				size_d    = rx_byte;
				pos_d     = '0;
				sum1_d    = '0;
				sum2_d    = '0;
				matched_d = 1'b0;
				phase_d   = (rx_byte < 8'd3) ? PH_HUNT : PH_BODY;
			end
			PH_BODY: begin
				pos_d = pos_q + 8'd1;
				if (pos3 < size9) begin
					sum1_d = sum1_new;
					sum2_d = sum2_q + sum1_new;
				end else if (pos3 == size9) begin
					matched_d = (rx_byte == sum1_q);
				end else if (pos2 == size9) begin
					matched_d = matched_q & (rx_byte == sum2_q);
				end else begin
					phase_d = PH_HUNT;
					pos_d   = '0;
				end
			end
			default: begin
				phase_d = PH_HUNT;
				if (match.hit) begin
					phase_d = PH_SIZE;
					type_d  = match.frame_type;
				end
			end
		endcase
	end

	// Result for the byte being processed.
	always_comb begin
		res = '0;
		case (phase_q)
			PH_SIZE: begin
				res.emit = 1'b1;
				if (rx_byte < 8'd3) begin
					res.item_kind = KIND_END;
					res.is_last   = 1'b1;
				end else begin
					res.item_kind      = KIND_START;
					res.data_byte      = tag_of(type_q);
					res.forward_length = rx_byte - 8'd2;
				end
			end
			PH_BODY: begin
				if (pos3 < size9) begin
					res.emit      = 1'b1;
					res.item_kind = KIND_PAYLOAD;
					res.data_byte = rx_byte;
				end else if ((pos3 != size9) && (pos2 != size9)) begin
					res.emit       = 1'b1;
					res.item_kind  = KIND_END;
					res.frame_good = matched_q;
					res.is_last    = 1'b1;
				end
			end
			default: begin
				res = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			type_q    <= '0;
			size_q    <= '0;
			pos_q     <= '0;
			sum1_q    <= '0;
			sum2_q    <= '0;
			matched_q <= 1'b0;
		end else if (step_en) begin
			phase_q   <= phase_d;
			type_q    <= type_d;
			size_q    <= size_d;
			pos_q     <= pos_d;
			sum1_q    <= sum1_d;
			sum2_q    <= sum2_d;
			matched_q <= matched_d;
		end
	end

endmodule

// File: hw/rtl/checksummed_frame_parser.sv
// Length-prefixed frame parser with Fletcher-8 checks, top level.
// A result passes the input register and then the result register before it is offered.
// Throughput: one byte per cycle; the single frame state update per byte sets the rate.
// Stalls only when the result register is full and not being taken.
// Reset: header registers return to 0xFF..0xF9, the parser hunts, both registers empty.
// Depends on cfp_pkg, cfp_hdr_match and cfp_frame_fsm.
module checksummed_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] data_byte, [15:8] forward_length, [16] frame_good
	output logic [1:0]  m_tuser,   // [1:0] item_kind
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [7:0]  cfg_data
);
	import cfp_pkg::*;

	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       out_valid_q;
	result_t    out_q;
	result_t    res;
	match_t     match;
	logic       advance;

	cfp_hdr_match u_match (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.rx_byte  (rx_byte_s1),
		.match    (match)
	);

	cfp_frame_fsm u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.rx_byte (rx_byte_s1),
		.match   (match),
		.res     (res)
	);

	// A byte with no result never waits on the output side.
	assign advance  = valid_s1 && (!res.emit || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			rx_byte_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.emit) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, out_q.frame_good, out_q.forward_length, out_q.data_byte};
	assign m_tuser  = out_q.item_kind;
	assign m_tlast  = out_q.is_last;

	// An end transfer carries no length and always closes the frame.
	a_end_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == KIND_END)) |-> (m_tlast && (m_tdata[15:0] == 16'd0)))
		else $error("frame end transfer malformed");

	// A start transfer forwards between 1 and 253 bytes and does not close the frame.
	a_start_len: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == KIND_START)) |->
		(!m_tlast && (m_tdata[15:8] != 8'd0) && (m_tdata[15:8] <= 8'd253)
		&& (m_tdata[7:0] >= 8'hF9)))
		else $error("frame start transfer malformed");

	// Only an end transfer may report a good frame.
	a_good_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[16]) |-> (m_tuser == KIND_END))
		else $error("good verdict outside frame end");

	// A held byte that produces a result waits only while the result register is blocked.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |-> (res.emit && out_valid_q && !m_tready))
		else $error("input stage stalled without cause");

endmodule

// File: sim/tb_checksummed_frame_parser.sv
// Self-checking testbench for checksummed_frame_parser: random byte streams of framed
// and stray bytes, a built-in frame predictor and an in-order result scoreboard.
// Depends on cfp_pkg and the checksummed_frame_parser RTL.
module tb_checksummed_frame_parser;
	import cfp_pkg::*;

	localparam int unsigned FRAME_BYTE_TARGET = 1950;
	localparam int unsigned HEADER_RELOAD_SPAN = 400;
	localparam int unsigned SINK_HOLD_CYCLES = 600;
	localparam int unsigned SINK_HOLD_AFTER = 150;
	localparam int unsigned DRAIN_CYCLES = 4;
	localparam logic [2:0] CFG_IDX_UNUSED = 3'd7;

	typedef struct {
		kind_t      kind;
		logic [7:0] data;
		logic [7:0] flen;
		logic       good;
		logic       last;
	} frame_item_t;

	// Tracks the parser state per accepted byte and holds the results still owed.
	class cfp_frame_checker;
		logic [7:0]  header_reg [NUM_TYPES];
		phase_t      phase;
		logic [2:0]  ftype;
		logic [7:0]  fsize;
		logic [7:0]  pos;
		logic [7:0]  sum1;
		logic [7:0]  sum2;
		logic        matched;
		frame_item_t owed_items [$];
		int unsigned mismatches;
		int unsigned checked;

		function new();
			for (int k = 0; k < NUM_TYPES; k++)
				header_reg[k] = 8'hFF - 8'(k);
			phase = PH_HUNT;
			ftype = '0;
			fsize = '0;
			pos = '0;
			sum1 = '0;
			sum2 = '0;
			matched = 1'b0;
			mismatches = 0;
			checked = 0;
		endfunction

		function void set_header(input logic [2:0] idx, input logic [7:0] val);
			if (idx < NUM_TYPES)
				header_reg[idx] = val;
		endfunction

		function void owe(input kind_t kind, input logic [7:0] data, input logic [7:0] flen,
			input logic good, input logic last);
			frame_item_t it;
			it.kind = kind;
			it.data = data;
			it.flen = flen;
			it.good = good;
			it.last = last;
			owed_items.push_back(it);
		endfunction

		function void take_byte(input logic [7:0] b);
			int unsigned p;
			int unsigned s;
			p = pos;
			s = fsize;
			case (phase)
				PH_SIZE: begin
					fsize = b;
					pos = '0;
					sum1 = '0;
					sum2 = '0;
					matched = 1'b0;
					if (b < 8'd3) begin
						phase = PH_HUNT;
						owe(KIND_END, 8'h00, 8'h00, 1'b0, 1'b1);
					end else begin
						phase = PH_BODY;
						owe(KIND_START, 8'hFF - {5'b0, ftype}, b - 8'd2, 1'b0, 1'b0);
					end
				end
				PH_BODY: begin
					pos = pos + 8'd1;
					if (p + 3 < s) begin
						sum1 = sum1 + b;
						sum2 = sum2 + sum1;
						owe(KIND_PAYLOAD, b, 8'h00, 1'b0, 1'b0);
					end else if (p + 3 == s) begin
						matched = (b == sum1);
					end else if (p + 2 == s) begin
						matched = matched & (b == sum2);
					end else begin
						// Trailer byte: its value is never checked.
						phase = PH_HUNT;
						pos = '0;
						owe(KIND_END, 8'h00, 8'h00, matched, 1'b1);
					end
				end
				default: begin
					phase = PH_HUNT;
					for (int k = NUM_TYPES - 1; k >= 0; k--) begin
						if (b == header_reg[k]) begin
							ftype = 3'(k);
							phase = PH_SIZE;
						end
					end
				end
			endcase
		endfunction

		function void check_item(input logic [1:0] kind, input logic [7:0] data,
			input logic [7:0] flen, input logic good, input logic last);
			frame_item_t e;
			checked++;
			if (owed_items.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: kind %0d data %02h len %0d good %0d last %0d",
						kind, data, flen, good, last);
				return;
			end
			e = owed_items.pop_front();
			if (e.kind !== kind || e.data !== data || e.flen !== flen || e.good !== good ||
				e.last !== last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch (expected/actual): kind %0d/%0d data %02h/%02h len %0d/%0d good %0d/%0d last %0d/%0d",
						e.kind, kind, e.data, data, e.flen, flen, e.good, good, e.last, last);
			end
		endfunction

		function int unsigned pending();
			return owed_items.size();
		endfunction

		function void note_leftover();
			if (owed_items.size() != 0) begin
				mismatches += owed_items.size();
				$display("%0d expected results never arrived", owed_items.size());
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_addr = 3'd0;
	logic [7:0]  cfg_data = 8'h00;

	cfp_frame_checker chk;
	logic [7:0]  header_plan [NUM_TYPES];
	bit          gaps_on = 1'b1;
	int unsigned frame_bytes = 0;
	logic [7:0]  directed_bytes [$];

	checksummed_frame_parser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	always #1 clk = ~clk;

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int n;
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		chk.take_byte(b);
		n = gaps_on ? gap_len() : 0;
		if (n != 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Fault 1 spoils sum1, fault 2 spoils sum2, fault 3 sends random sums.
	task automatic send_frame(input logic [7:0] hdr, input logic [7:0] size, input int fault);
		logic [7:0] a;
		logic [7:0] c;
		logic [7:0] b;
		send_byte(hdr);
		send_byte(size);
		frame_bytes += (size < 8'd3) ? 2 : size + 2;
		if (size < 8'd3)
			return;
		a = '0;
		c = '0;
		for (int i = 0; i < size - 3; i++) begin
			b = 8'($urandom);
			a = a + b;
			c = c + a;
			send_byte(b);
		end
		send_byte(fault == 1 ? a ^ 8'($urandom_range(1, 255)) : (fault == 3 ? 8'($urandom) : a));
		send_byte(fault == 2 ? c ^ 8'($urandom_range(1, 255)) : (fault == 3 ? 8'($urandom) : c));
		send_byte(8'($urandom));
	endtask

	// Lets every owed result out, then waits for a byte still in flight that owes none.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (chk.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_headers();
		drain();
		for (int i = 0; i < NUM_TYPES; i++) begin
			cfg_we <= 1'b1;
			cfg_addr <= 3'(i);
			cfg_data <= header_plan[i];
			@(posedge clk);
			chk.set_header(3'(i), header_plan[i]);
		end
		// The index past the last header register must change nothing.
		cfg_we <= 1'b1;
		cfg_addr <= CFG_IDX_UNUSED;
		cfg_data <= 8'($urandom);
		@(posedge clk);
		chk.set_header(CFG_IDX_UNUSED, cfg_data);
		cfg_we <= 1'b0;
	endtask

	// Extremes and duplicated headers are favored so the priority rule gets exercised.
	task automatic pick_headers();
		int r;
		for (int i = 0; i < NUM_TYPES; i++) begin
			r = $urandom_range(0, 99);
			if (r < 20)
				header_plan[i] = 8'h00;
			else if (r < 40)
				header_plan[i] = 8'hFF;
			else if (r < 60 && i > 0)
				header_plan[i] = header_plan[$urandom_range(0, i - 1)];
			else
				header_plan[i] = 8'($urandom);
		end
	endtask

	task automatic result_cycle();
		@(posedge clk);
		if (m_tvalid && m_tready)
			chk.check_item(m_tuser, m_tdata[7:0], m_tdata[15:8], m_tdata[16], m_tlast);
	endtask

	initial begin : result_sink
		int n;
		bit held;
		held = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (!held && chk.checked >= SINK_HOLD_AFTER) begin
				// Long hold-off while the sender keeps offering, so the input stalls.
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (SINK_HOLD_CYCLES) result_cycle();
			end
			n = gap_len();
			if (n != 0) begin
				m_tready <= 1'b0;
				repeat (n) result_cycle();
			end
			m_tready <= 1'b1;
			n = $urandom_range(1, 24);
			repeat (n) result_cycle();
		end
	end

	initial begin : byte_source
		int k;
		int r;
		int fault;
		int unsigned next_reload;
		logic [7:0] size;
		chk = new();
		for (int i = 0; i < NUM_TYPES; i++)
			header_plan[i] = 8'hFF - 8'(i);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Stray byte, short sizes, an empty frame, a two-byte frame whose sum1 wraps
		// to zero, and a frame with a wrong sum1, all under the reset headers.
		directed_bytes = '{8'h00, 8'hF9, 8'h00, 8'hFF, 8'h01,
			8'hFD, 8'h03, 8'h00, 8'h00, 8'hAA,
			8'hFC, 8'h05, 8'hFF, 8'h01, 8'h00, 8'hFF, 8'h55,
			8'hFB, 8'h04, 8'h80, 8'h81, 8'h80, 8'h00};
		foreach (directed_bytes[i])
			send_byte(directed_bytes[i]);

		// Duplicated headers: 0x7E must pick type 1 and 0x00 type 0.
		header_plan = '{8'h00, 8'h7E, 8'h7E, 8'hFF, 8'h00, 8'hA5, 8'h5A};
		write_headers();
		send_frame(8'h7E, 8'd3, 0);
		send_frame(8'h00, 8'd4, 0);
		send_frame(8'hFF, 8'd255, 0);

		next_reload = HEADER_RELOAD_SPAN;
		while (frame_bytes < FRAME_BYTE_TARGET) begin
			if (frame_bytes >= next_reload) begin
				pick_headers();
				write_headers();
				next_reload += HEADER_RELOAD_SPAN;
			end
			gaps_on = $urandom_range(0, 3) != 0;
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
			k = $urandom_range(0, NUM_TYPES - 1);
			r = $urandom_range(0, 99);
			if (r < 3)
				size = 8'd255;
			else if (r < 12)
				size = 8'($urandom_range(0, 2));
			else if (r < 17)
				size = 8'($urandom_range(21, 254));
			else
				size = 8'($urandom_range(3, 20));
			fault = ($urandom_range(0, 9) < 2) ? $urandom_range(1, 3) : 0;
			send_frame(header_plan[k], size, fault);
		end

		drain();
		repeat (10) @(posedge clk);
		chk.note_leftover();
		if (chk.mismatches == 0)
			$display("checksummed_frame_parser test passed");
		else
			$display("checksummed_frame_parser test failed");
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("checksummed_frame_parser test failed");
		$finish;
	end

endmodule
